[hdl/ddwt_pkg.sv]
// ----------------------------------------------------------------------------
// ddwt_pkg
// Shared types, constants and the microcode program of the differential
// drive controller with watchdog stop and motor heat estimate.
// ----------------------------------------------------------------------------
package ddwt_pkg;

	// apb address width: eight 32-bit registers at 4*i
	localparam int ADDR_W = 5;

	// register reset values
	localparam logic [15:0] DUTY_FULL_RESET    = 16'd1024;
	localparam logic [8:0]  THROTTLE_RESET     = 9'd256;
	localparam logic [15:0] WD_TICKS_RESET     = 16'd10;
	localparam logic [15:0] TH_TICKS_RESET     = 16'd10;
	localparam logic [15:0] AMBIENT_RESET      = 16'd6400;
	localparam logic [31:0] HEAT_GAIN_RESET    = 32'd65536;
	localparam logic [31:0] INV_CAP_RESET      = 32'd65536;
	localparam logic [31:0] LOSS_GAIN_RESET    = 32'd6554;

	// ceil(2^32 / 125): exact floor division by 125 for values below 2^25
	localparam logic [31:0] RECIP_125 = 32'd34359739;

	// temperature rise cap, 2^20 in Q8.8 units
	localparam logic [20:0] RISE_CAP = 21'h100000;

	// register map
	typedef enum logic [2:0] {
		REG_DUTY_FULL,
		REG_THROTTLE,
		REG_WD_TICKS,
		REG_TH_TICKS,
		REG_AMBIENT,
		REG_HEAT_GAIN,
		REG_INV_CAP,
		REG_LOSS_GAIN
	} reg_idx_t;

	// configuration as seen by the datapath
	typedef struct packed {
		logic [15:0] duty_full;
		logic [8:0]  throttle;
		logic [15:0] wd_ticks;
		logic [15:0] th_ticks;
		logic [15:0] ambient;    // signed Q8.8
		logic [31:0] heat_gain;  // Q16.16
		logic [31:0] inv_cap;    // Q16.16
		logic [31:0] loss_gain;  // Q16.16
	} cfg_t;

	// multiplier operand selects
	typedef enum logic [2:0] {
		MA_LSTICK,
		MA_RSTICK,
		MA_PROD_LO,
		MA_PROD_SH10,
		MA_SUM,
		MA_HEAT_LO,
		MA_HEAT_HI,
		MA_DT
	} ma_sel_t;

	typedef enum logic [2:0] {
		MB_RANGE,
		MB_THROTTLE,
		MB_RECIP,
		MB_HEAT_GAIN,
		MB_INV_CAP,
		MB_LOSS_GAIN
	} mb_sel_t;

	// register update done by a step
	typedef enum logic [3:0] {
		WB_NONE,
		WB_LEFT,
		WB_RIGHT,
		WB_TICK,
		WB_HEAT_IN,
		WB_HEAT_MAG,
		WB_ACC_LO,
		WB_ACC_HI,
		WB_TEMP,
		WB_HEAT_LOSS,
		WB_FINISH
	} wb_op_t;

	// jump conditions
	typedef enum logic [1:0] {
		JC_NONE,
		JC_ALWAYS,
		JC_TICK,
		JC_NO_THERM
	} jc_t;

	localparam int PC_W = 5;
	localparam logic [PC_W-1:0] STEP_START  = 5'd0;
	localparam logic [PC_W-1:0] STEP_TICK   = 5'd7;
	localparam logic [PC_W-1:0] STEP_FINISH = 5'd17;

	typedef struct packed {
		logic            mul_en;
		ma_sel_t         ma;
		mb_sel_t         mb;
		wb_op_t          wb;
		jc_t             jc;
		logic [PC_W-1:0] target;
	} ucode_t;

	// sequencer to datapath
	typedef struct packed {
		logic   load;
		logic   run;
		ucode_t uc;
	} ctl_t;

	// datapath to sequencer
	typedef struct packed {
		logic is_tick;
		logic no_therm;
		logic out_free;
	} status_t;

	localparam ucode_t UC_NOP = '{
		mul_en: 1'b0,
		ma:     MA_LSTICK,
		mb:     MB_RANGE,
		wb:     WB_NONE,
		jc:     JC_NONE,
		target: STEP_START
	};

	// microcode program: the product register feeds the step after a multiply
	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		w = UC_NOP;
		case (pc)
			// stick path, left side; a tick branches away
			5'd0: begin
				w.mul_en = 1'b1; w.ma = MA_LSTICK; w.mb = MB_RANGE;
				w.jc = JC_TICK; w.target = STEP_TICK;
			end
			5'd1: begin
				w.mul_en = 1'b1; w.ma = MA_PROD_LO; w.mb = MB_THROTTLE;
			end
			5'd2: begin
				w.mul_en = 1'b1; w.ma = MA_PROD_SH10; w.mb = MB_RECIP;
			end
			// right side, left duty written back
			5'd3: begin
				w.mul_en = 1'b1; w.ma = MA_RSTICK; w.mb = MB_RANGE;
				w.wb = WB_LEFT;
			end
			5'd4: begin
				w.mul_en = 1'b1; w.ma = MA_PROD_LO; w.mb = MB_THROTTLE;
			end
			5'd5: begin
				w.mul_en = 1'b1; w.ma = MA_PROD_SH10; w.mb = MB_RECIP;
			end
			5'd6: begin
				w.wb = WB_RIGHT; w.jc = JC_ALWAYS; w.target = STEP_FINISH;
			end
			// tick: counters, then thermal update when due
			5'd7: begin
				w.wb = WB_TICK; w.jc = JC_NO_THERM; w.target = STEP_FINISH;
			end
			5'd8: begin
				w.mul_en = 1'b1; w.ma = MA_SUM; w.mb = MB_HEAT_GAIN;
			end
			5'd9: begin
				w.wb = WB_HEAT_IN;
			end
			5'd10: begin
				w.wb = WB_HEAT_MAG;
			end
			5'd11: begin
				w.mul_en = 1'b1; w.ma = MA_HEAT_LO; w.mb = MB_INV_CAP;
			end
			5'd12: begin
				w.mul_en = 1'b1; w.ma = MA_HEAT_HI; w.mb = MB_INV_CAP;
				w.wb = WB_ACC_LO;
			end
			5'd13: begin
				w.wb = WB_ACC_HI;
			end
			5'd14: begin
				w.wb = WB_TEMP;
			end
			5'd15: begin
				w.mul_en = 1'b1; w.ma = MA_DT; w.mb = MB_LOSS_GAIN;
			end
			5'd16: begin
				w.wb = WB_HEAT_LOSS;
			end
			STEP_FINISH: begin
				w.wb = WB_FINISH;
			end
			default: begin
				w.wb = WB_FINISH;
			end
		endcase
		return w;
	endfunction

endpackage

[hdl/differential_drive_watchdog_thermal.sv]
// ----------------------------------------------------------------------------
// differential_drive_watchdog_thermal
// Two H-bridge duty generator from stick commands, with watchdog stop and a
// first-order motor heat estimate.
// ----------------------------------------------------------------------------
// Usage:
// - input channel (in_valid/in_ready): op 0 is a stick command, op 1 a timer
//   tick. One word is taken when the block is idle.
// - output channel (out_valid/out_ready): one result word per input word,
//   held in an output register until taken.
// - APB port: eight registers at byte address 4*i, write only while idle.
// - all work runs on one shared 32x32 multiplier stepped by a microcode
//   program; the output register is loaded on the last step.
// - a new word is taken the cycle after the result is loaded, so the block
//   handles one word at a time.
// - a stalled receiver holds the result; the next word is still taken and
//   processed, and the block waits on its last step until the output
//   register is free.
// - reset clears counters, heat, duties and the output valid, sets the
//   temperature estimate and registers to their defaults.
// ----------------------------------------------------------------------------
module differential_drive_watchdog_thermal import ddwt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic signed [9:0]  left_stick,
	input  logic signed [9:0]  right_stick,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        left_fwd_duty,
	output logic [15:0]        left_rev_duty,
	output logic [15:0]        right_rev_duty,
	output logic [15:0]        right_fwd_duty,
	output logic signed [15:0] motor_temp,
	output logic               watchdog_stop,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	cfg_t    cfg;
	ctl_t    ctl;
	status_t st;

	// configuration registers
	ddwt_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// microcode sequencer
	ddwt_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.ctl      (ctl)
	);

	// datapath
	ddwt_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.ctl            (ctl),
		.op             (op),
		.left_stick     (left_stick),
		.right_stick    (right_stick),
		.st             (st),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_fwd_duty  (left_fwd_duty),
		.left_rev_duty  (left_rev_duty),
		.right_rev_duty (right_rev_duty),
		.right_fwd_duty (right_fwd_duty),
		.motor_temp     (motor_temp),
		.watchdog_stop  (watchdog_stop)
	);

endmodule

[hdl/ddwt_regs.sv]
// ----------------------------------------------------------------------------
// ddwt_regs
// APB register file: eight configuration registers at byte address 4*i,
// written in the access phase, read back combinationally.
// ----------------------------------------------------------------------------
module ddwt_regs import ddwt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_full <= DUTY_FULL_RESET;
			cfg_q.throttle  <= THROTTLE_RESET;
			cfg_q.wd_ticks  <= WD_TICKS_RESET;
			cfg_q.th_ticks  <= TH_TICKS_RESET;
			cfg_q.ambient   <= AMBIENT_RESET;
			cfg_q.heat_gain <= HEAT_GAIN_RESET;
			cfg_q.inv_cap   <= INV_CAP_RESET;
			cfg_q.loss_gain <= LOSS_GAIN_RESET;
		end else if (wr) begin
			case (idx)
				REG_DUTY_FULL: cfg_q.duty_full <= pwdata[15:0];
				REG_THROTTLE:  cfg_q.throttle  <= pwdata[8:0];
				REG_WD_TICKS:  cfg_q.wd_ticks  <= pwdata[15:0];
				REG_TH_TICKS:  cfg_q.th_ticks  <= pwdata[15:0];
				REG_AMBIENT:   cfg_q.ambient   <= pwdata[15:0];
				REG_HEAT_GAIN: cfg_q.heat_gain <= pwdata;
				REG_INV_CAP:   cfg_q.inv_cap   <= pwdata;
				REG_LOSS_GAIN: cfg_q.loss_gain <= pwdata;
				default: ;
			endcase
		end
	end

	// read mux, ambient sign extended
	always_comb begin
		case (idx)
			REG_DUTY_FULL: prdata = {16'b0, cfg_q.duty_full};
			REG_THROTTLE:  prdata = {23'b0, cfg_q.throttle};
			REG_WD_TICKS:  prdata = {16'b0, cfg_q.wd_ticks};
			REG_TH_TICKS:  prdata = {16'b0, cfg_q.th_ticks};
			REG_AMBIENT:   prdata = {{16{cfg_q.ambient[15]}}, cfg_q.ambient};
			REG_HEAT_GAIN: prdata = cfg_q.heat_gain;
			REG_INV_CAP:   prdata = cfg_q.inv_cap;
			REG_LOSS_GAIN: prdata = cfg_q.loss_gain;
			default:       prdata = '0;
		endcase
	end

endmodule

[hdl/ddwt_seq.sv]
// ----------------------------------------------------------------------------
// ddwt_seq
// Microcode sequencer: step counter, program table lookup, conditional
// jumps, input handshake and stall at the finish step while the output is full.
// ----------------------------------------------------------------------------
module ddwt_seq import ddwt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output ctl_t    ctl
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	ucode_t          uc;
	logic            stall;
	logic            run;
	logic            take_jump;

	assign uc       = ucode_rom(pc_q);
	assign stall    = (uc.wb == WB_FINISH) && !st.out_free;
	assign run      = busy_q && !stall;
	assign in_ready = !busy_q;

	assign ctl.load = in_valid && !busy_q;
	assign ctl.run  = run;
	assign ctl.uc   = uc;

	// jump condition
	always_comb begin
		case (uc.jc)
			JC_NONE:     take_jump = 1'b0;
			JC_ALWAYS:   take_jump = 1'b1;
			JC_TICK:     take_jump = st.is_tick;
			JC_NO_THERM: take_jump = st.no_therm;
			default:     take_jump = 1'b0;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= STEP_START;
		end else if (!busy_q) begin
			if (in_valid) begin
				busy_q <= 1'b1;
				pc_q   <= STEP_START;
			end
		end else if (run) begin
			if (uc.wb == WB_FINISH) begin
				busy_q <= 1'b0;
			end
			pc_q <= take_jump ? uc.target : pc_q + 1'b1;
		end
	end

endmodule

[hdl/ddwt_dp.sv]
// ----------------------------------------------------------------------------
// ddwt_dp
// Datapath: input word latch, one shared 32x32 multiplier with a product
// register, drive and thermal state, and the output register.
// ----------------------------------------------------------------------------
module ddwt_dp import ddwt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  ctl_t               ctl,
	input  logic               op,
	input  logic signed [9:0]  left_stick,
	input  logic signed [9:0]  right_stick,
	output status_t            st,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        left_fwd_duty,
	output logic [15:0]        left_rev_duty,
	output logic [15:0]        right_rev_duty,
	output logic [15:0]        right_fwd_duty,
	output logic signed [15:0] motor_temp,
	output logic               watchdog_stop
);

	// saturate a 52-bit two's complement value to 48 bits
	function automatic logic [47:0] sat48(input logic [51:0] v);
		logic in_range;
		in_range = (&v[51:47]) || (~|v[51:47]);
		if (in_range) begin
			return v[47:0];
		end
		return v[51] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
	endfunction

	// latched input word
	logic        op_q;
	logic [9:0]  lstick_q;
	logic [9:0]  rstick_q;

	// drive and thermal state
	logic [15:0] wd_cnt_q;
	logic [15:0] th_cnt_q;
	logic [47:0] heat_q;
	logic [15:0] lmag_q;
	logic [15:0] rmag_q;
	logic        lfwd_q;
	logic        rfwd_q;
	logic [15:0] temp_q;
	logic        stop_q;

	// scratch
	logic [63:0] prod_q;
	logic        hneg_q;
	logic [47:0] hmag_q;
	logic [79:0] acc_q;

	// output register
	logic        out_valid_q;
	logic [15:0] lfd_q, lrd_q, rrd_q, rfd_q, temp_out_q;
	logic        stop_out_q;

	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [9:0]  labs;
	logic [9:0]  rabs;
	logic [15:0] duty_sat;
	logic [16:0] wd_next;
	logic [16:0] th_next;
	logic        wd_hit;
	logic        th_hit;
	logic [16:0] sum17;
	logic [48:0] heat_inc;
	logic [51:0] heat52;
	logic [51:0] heat_in52;
	logic [47:0] heat_abs;
	logic [79:0] acc_hi_sum;
	logic [20:0] rise;
	logic [21:0] rise22;
	logic [21:0] diff22;
	logic [21:0] temp_sum;
	logic [15:0] temp_sat;
	logic [16:0] dt17;
	logic [16:0] dt_abs;
	logic [51:0] loss52;
	logic [51:0] heat_loss52;

	// stick magnitudes
	assign labs = lstick_q[9] ? (~lstick_q + 10'd1) : lstick_q;
	assign rabs = rstick_q[9] ? (~rstick_q + 10'd1) : rstick_q;

	// duty from the reciprocal product, saturated at the range
	assign duty_sat = (prod_q[63:32] > {16'b0, cfg.duty_full}) ?
		cfg.duty_full : prod_q[47:32];

	// tick counters
	assign wd_next = {1'b0, wd_cnt_q} + 17'd1;
	assign th_next = {1'b0, th_cnt_q} + 17'd1;
	assign wd_hit  = wd_next >= {1'b0, cfg.wd_ticks};
	assign th_hit  = th_next >= {1'b0, cfg.th_ticks};

	// heat input: low product plus the gain for the top bit of the sum
	assign sum17     = {1'b0, lmag_q} + {1'b0, rmag_q};
	assign heat_inc  = {1'b0, prod_q[47:0]} +
		(sum17[16] ? {1'b0, cfg.heat_gain, 16'b0} : 49'd0);
	assign heat52    = {{4{heat_q[47]}}, heat_q};
	assign heat_in52 = heat52 + {3'b0, heat_inc};
	assign heat_abs  = heat_q[47] ? (~heat_q + 48'd1) : heat_q;

	// temperature rise, magnitude capped, then signed and added to ambient
	assign acc_hi_sum = acc_q + {prod_q[47:0], 32'b0};
	assign rise       = (acc_q[79:24] > {35'b0, RISE_CAP}) ? RISE_CAP : acc_q[44:24];
	assign rise22     = {1'b0, rise};
	assign diff22     = hneg_q ? (~rise22 + 22'd1) : rise22;
	assign temp_sum   = {{6{cfg.ambient[15]}}, cfg.ambient} + diff22;
	assign temp_sat   = ((&temp_sum[21:15]) || (~|temp_sum[21:15])) ? temp_sum[15:0] :
		(temp_sum[21] ? 16'h8000 : 16'h7fff);

	// heat loss from the saturated temperature
	assign dt17        = {temp_q[15], temp_q} - {cfg.ambient[15], cfg.ambient};
	assign dt_abs      = dt17[16] ? (~dt17 + 17'd1) : dt17;
	assign loss52      = {12'b0, prod_q[47:8]};
	assign heat_loss52 = dt17[16] ? (heat52 + loss52) : (heat52 - loss52);

	// multiplier operands
	always_comb begin
		case (ctl.uc.ma)
			MA_LSTICK:    mul_a = {22'b0, labs};
			MA_RSTICK:    mul_a = {22'b0, rabs};
			MA_PROD_LO:   mul_a = prod_q[31:0];
			MA_PROD_SH10: mul_a = prod_q[41:10];
			MA_SUM:       mul_a = {16'b0, sum17[15:0]};
			MA_HEAT_LO:   mul_a = hmag_q[31:0];
			MA_HEAT_HI:   mul_a = {16'b0, hmag_q[47:32]};
			MA_DT:        mul_a = {16'b0, dt_abs[15:0]};
			default:      mul_a = '0;
		endcase
		case (ctl.uc.mb)
			MB_RANGE:     mul_b = {16'b0, cfg.duty_full};
			MB_THROTTLE:  mul_b = {23'b0, cfg.throttle};
			MB_RECIP:     mul_b = RECIP_125;
			MB_HEAT_GAIN: mul_b = cfg.heat_gain;
			MB_INV_CAP:   mul_b = cfg.inv_cap;
			MB_LOSS_GAIN: mul_b = cfg.loss_gain;
			default:      mul_b = '0;
		endcase
	end

	// input latch, product and scratch registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q     <= op;
			lstick_q <= left_stick;
			rstick_q <= right_stick;
		end
		if (ctl.run && ctl.uc.mul_en) begin
			prod_q <= {32'b0, mul_a} * {32'b0, mul_b};
		end
		if (ctl.run) begin
			case (ctl.uc.wb)
				WB_HEAT_MAG: begin
					hneg_q <= heat_q[47];
					hmag_q <= heat_abs;
				end
				WB_ACC_LO: acc_q <= {16'b0, prod_q};
				WB_ACC_HI: acc_q <= acc_hi_sum;
				default: ;
			endcase
		end
	end

	// drive and thermal state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wd_cnt_q <= '0;
			th_cnt_q <= '0;
			heat_q   <= '0;
			lmag_q   <= '0;
			rmag_q   <= '0;
			lfwd_q   <= 1'b0;
			rfwd_q   <= 1'b0;
			temp_q   <= AMBIENT_RESET;
			stop_q   <= 1'b0;
		end else if (ctl.run) begin
			case (ctl.uc.wb)
				WB_LEFT: begin
					lmag_q <= duty_sat;
					lfwd_q <= !lstick_q[9] && (lstick_q != '0);
					stop_q <= 1'b0;
				end
				WB_RIGHT: begin
					rmag_q   <= duty_sat;
					rfwd_q   <= !rstick_q[9] && (rstick_q != '0);
					wd_cnt_q <= '0;
				end
				WB_TICK: begin
					stop_q   <= wd_hit;
					wd_cnt_q <= wd_hit ? 16'd0 : wd_next[15:0];
					th_cnt_q <= th_hit ? 16'd0 : th_next[15:0];
					if (wd_hit) begin
						lmag_q <= '0;
						rmag_q <= '0;
					end
				end
				WB_HEAT_IN:   heat_q <= sat48(heat_in52);
				WB_TEMP:      temp_q <= temp_sat;
				WB_HEAT_LOSS: heat_q <= sat48(heat_loss52);
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.run && (ctl.uc.wb == WB_FINISH)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.run && (ctl.uc.wb == WB_FINISH)) begin
			lfd_q      <= lfwd_q ? lmag_q : 16'd0;
			lrd_q      <= lfwd_q ? 16'd0 : lmag_q;
			rrd_q      <= rfwd_q ? 16'd0 : rmag_q;
			rfd_q      <= rfwd_q ? rmag_q : 16'd0;
			temp_out_q <= temp_q;
			stop_out_q <= stop_q;
		end
	end

	assign st.is_tick  = op_q;
	assign st.no_therm = !th_hit;
	assign st.out_free = !out_valid_q || out_ready;

	assign out_valid      = out_valid_q;
	assign left_fwd_duty  = lfd_q;
	assign left_rev_duty  = lrd_q;
	assign right_rev_duty = rrd_q;
	assign right_fwd_duty = rfd_q;
	assign motor_temp     = temp_out_q;
	assign watchdog_stop  = stop_out_q;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives stick commands and timer ticks into the differential drive block,
// predicts each result word (bridge duties, watchdog stop, heat estimate)
// from a behavioral copy of its state and registers, and compares every
// accepted result with the oldest prediction. Registers are rewritten over
// the APB port between phases, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import ddwt_pkg::*;

	localparam logic OP_STICK = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	localparam int CYCLE_LIMIT   = 600000;
	localparam int TAIL_CYCLES   = 20;
	localparam int PHASE_WORDS   = 125;
	localparam int RANDOM_PHASES = 10;
	localparam int HOLD_PHASE    = 5;
	localparam int HOLD_CYCLES   = 400;

	localparam longint          HEAT_HI  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint          HEAT_LO  = -HEAT_HI - 1;
	localparam longint unsigned DUTY_DIV = 500 * 256;
	localparam longint unsigned TEMP_CAP = 64'd1 << 20;

	typedef struct packed {
		logic       op;
		logic [9:0] ls;
		logic [9:0] rs;
	} drive_cmd_t;

	typedef struct packed {
		logic [15:0] lf;
		logic [15:0] lr;
		logic [15:0] rr;
		logic [15:0] rf;
		logic [15:0] temp;
		logic        stop;
	} bridge_out_t;

	// dut ports
	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               op = 1'b0;
	logic signed [9:0]  left_stick = '0;
	logic signed [9:0]  right_stick = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        left_fwd_duty;
	logic [15:0]        left_rev_duty;
	logic [15:0]        right_rev_duty;
	logic [15:0]        right_fwd_duty;
	logic signed [15:0] motor_temp;
	logic               watchdog_stop;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	// stimulus and scoreboard
	drive_cmd_t  cmd_q[$];
	bridge_out_t bridge_exp_q[$];
	int          items_queued = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          cycle_cnt = 0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          hold_cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_used = 1'b0;
	int          words_accepted = 0;
	int          words_handled = 0;

	// register mirror
	int unsigned m_range    = DUTY_FULL_RESET;
	int unsigned m_throttle = THROTTLE_RESET;
	int unsigned m_wd       = WD_TICKS_RESET;
	int unsigned m_th       = TH_TICKS_RESET;
	int          m_amb      = $signed(AMBIENT_RESET);
	int unsigned m_gain     = HEAT_GAIN_RESET;
	int unsigned m_invcap   = INV_CAP_RESET;
	int unsigned m_loss     = LOSS_GAIN_RESET;

	// predicted block state
	int unsigned wd_cnt   = 0;
	int unsigned th_cnt   = 0;
	longint      heat_acc = 0;
	int unsigned lmag     = 0;
	int unsigned rmag     = 0;
	bit          lfwd     = 1'b0;
	bit          rfwd     = 1'b0;
	int          temp_est = $signed(AMBIENT_RESET);

	differential_drive_watchdog_thermal i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.left_stick     (left_stick),
		.right_stick    (right_stick),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_fwd_duty  (left_fwd_duty),
		.left_rev_duty  (left_rev_duty),
		.right_rev_duty (right_rev_duty),
		.right_fwd_duty (right_fwd_duty),
		.motor_temp     (motor_temp),
		.watchdog_stop  (watchdog_stop),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always #6 clk = ~clk;

	function automatic longint sat_heat(input longint v);
		if (v > HEAT_HI) return HEAT_HI;
		if (v < HEAT_LO) return HEAT_LO;
		return v;
	endfunction

	function automatic int sat_temp(input int v);
		if (v > 32767) return 32767;
		if (v < -32768) return -32768;
		return v;
	endfunction

	// |stick| * range * throttle / (500 * 256), clamped at range
	function automatic int unsigned stick_duty(input logic signed [9:0] stick);
		int              sv;
		longint unsigned mag;
		longint unsigned d;
		sv = stick;
		mag = (sv < 0) ? -sv : sv;
		d = mag * m_range * m_throttle / DUTY_DIV;
		return (d > m_range) ? m_range : int'(d);
	endfunction

	// first-order heat model update
	task automatic heat_update();
		longint unsigned sum;
		longint unsigned mag;
		longint unsigned a;
		longint unsigned b;
		longint unsigned rise;
		longint unsigned dmag;
		longint          heat;
		longint          loss;
		bit              neg;
		int              diff;
		int              temp;
		int              dt;
		sum = longint'(lmag) + longint'(rmag);
		heat = sat_heat(heat_acc + longint'(sum * m_gain));
		neg = heat < 0;
		mag = neg ? longint'(-heat) : longint'(heat);
		a = mag * (m_invcap >> 16);
		b = (mag * (m_invcap & 32'hFFFF)) >> 16;
		rise = (a + b) >> 8;
		if (rise > TEMP_CAP) rise = TEMP_CAP;
		diff = neg ? -int'(rise) : int'(rise);
		temp = sat_temp(m_amb + diff);
		temp_est = temp;
		dt = temp - m_amb;
		dmag = (dt < 0) ? -dt : dt;
		loss = longint'((dmag * m_loss) >> 8);
		if (dt < 0) loss = -loss;
		heat_acc = sat_heat(heat - loss);
	endtask

	// work out the result word of one accepted input word
	task automatic bridge_predict(input logic cmd_op, input logic signed [9:0] ls,
			input logic signed [9:0] rs);
		bridge_out_t r;
		int unsigned w;
		int unsigned t;
		r.stop = 1'b0;
		if (cmd_op == OP_STICK) begin
			wd_cnt = 0;
			lmag = stick_duty(ls);
			rmag = stick_duty(rs);
			lfwd = ls > 0;
			rfwd = rs > 0;
		end else begin
			w = wd_cnt + 1;
			if (w >= m_wd) begin
				lmag = 0;
				rmag = 0;
				w = 0;
				r.stop = 1'b1;
			end
			wd_cnt = w & 16'hFFFF;
			t = th_cnt + 1;
			if (t >= m_th) begin
				heat_update();
				t = 0;
			end
			th_cnt = t & 16'hFFFF;
		end
		r.lf = lfwd ? lmag[15:0] : 16'd0;
		r.lr = lfwd ? 16'd0 : lmag[15:0];
		r.rr = rfwd ? 16'd0 : rmag[15:0];
		r.rf = rfwd ? rmag[15:0] : 16'd0;
		r.temp = temp_est[15:0];
		bridge_exp_q.insert(bridge_exp_q.size(), r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= 50)
			$display("mismatch at result %0d: %s got %0d expected %0d",
				results_seen, what, got, want);
	endtask

	// register mirror follows apb writes
	always @(posedge clk) begin
		if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[4:2]))
				REG_DUTY_FULL: m_range = pwdata[15:0];
				REG_THROTTLE:  m_throttle = pwdata[8:0];
				REG_WD_TICKS:  m_wd = pwdata[15:0];
				REG_TH_TICKS:  m_th = pwdata[15:0];
				REG_AMBIENT:   m_amb = $signed(pwdata[15:0]);
				REG_HEAT_GAIN: m_gain = pwdata;
				REG_INV_CAP:   m_invcap = pwdata;
				REG_LOSS_GAIN: m_loss = pwdata;
				default: ;
			endcase
		end
	end

	// input word accepted: predict its result
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			bridge_predict(op, left_stick, right_stick);
			words_accepted++;
		end
	end

	// driver: offers the next pending word at the falling edge
	always @(negedge clk) begin : driver
		drive_cmd_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || (words_handled != words_accepted)) begin
			words_handled = words_accepted;
			if (cmd_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				c = cmd_q.pop_front();
				op <= c.op;
				left_stick <= c.ls;
				right_stick <= c.rs;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus a single long hold-off
	always @(negedge clk) begin
		if (hold_req && !hold_used) begin
			hold_used <= 1'b1;
			hold_cycles <= HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// monitor: compare each result word with the oldest prediction
	always @(posedge clk) begin : monitor
		bridge_out_t e;
		if (arst_n && out_valid && out_ready) begin
			if (bridge_exp_q.size() == 0) begin
				report_mismatch("result with nothing expected", 0, 0);
			end else begin
				e = bridge_exp_q.pop_front();
				if (left_fwd_duty !== e.lf)
					report_mismatch("left_fwd_duty", left_fwd_duty, e.lf);
				if (left_rev_duty !== e.lr)
					report_mismatch("left_rev_duty", left_rev_duty, e.lr);
				if (right_rev_duty !== e.rr)
					report_mismatch("right_rev_duty", right_rev_duty, e.rr);
				if (right_fwd_duty !== e.rf)
					report_mismatch("right_fwd_duty", right_fwd_duty, e.rf);
				if (motor_temp !== e.temp)
					report_mismatch("motor_temp", motor_temp, $signed(e.temp));
				if (watchdog_stop !== e.stop)
					report_mismatch("watchdog_stop", watchdog_stop, e.stop);
			end
			results_seen++;
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_cmd(input logic cmd_op, input logic [9:0] ls, input logic [9:0] rs);
		drive_cmd_t c;
		c.op = cmd_op;
		c.ls = ls;
		c.rs = rs;
		cmd_q.insert(cmd_q.size(), c);
		items_queued++;
	endtask

	function automatic logic [9:0] pick_stick();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 7))
			0: return 10'sd500;
			1: return -10'sd500;
			2: return 10'd0;
			default: return r[9:0];
		endcase
	endfunction

	function automatic logic [31:0] pick_gain();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1 << 20);
			2: return 32'd65536;
			default: return $urandom_range(0, 1 << 17);
		endcase
	endfunction

	task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin : stimulus
		logic [31:0] cfg_vals[8];
		logic [31:0] r;
		int          start;
		int          burst;
		int          wd_hint;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed words on reset settings: ticks, extremes, zero stick,
		// thermal update with live duties, then watchdog stop
		repeat (3) push_cmd(OP_TICK, 10'd0, 10'd0);
		push_cmd(OP_STICK, 10'sd500, -10'sd500);
		push_cmd(OP_STICK, 10'sd511, -10'sd512);
		push_cmd(OP_STICK, 10'd0, 10'd0);
		push_cmd(OP_STICK, -10'sd1, 10'sd1);
		push_cmd(OP_STICK, 10'sd250, -10'sd250);
		repeat (10) push_cmd(OP_TICK, 10'h3FF, 10'h155);
		push_cmd(OP_STICK, -10'sd512, 10'sd511);
		repeat (2) push_cmd(OP_TICK, 10'h2AA, 10'h3FF);

		for (int p = 1; p <= RANDOM_PHASES; p++) begin
			// block idle before the registers change
			while (results_seen != items_queued) @(negedge clk);

			case (p)
				1: cfg_vals = '{32'hFFFF, 32'h1FF, 32'hFFFF, 32'd1, 32'h7FFF,
					32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
				2: cfg_vals = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h8000,
					32'd0, 32'd0, 32'd0};
				3: cfg_vals = '{32'd1, 32'd256, 32'd1, 32'hFFFF, 32'd0,
					32'd65536, 32'd65536, 32'd6554};
				default: begin
					r = $urandom;
					cfg_vals[REG_DUTY_FULL] = $urandom_range(1, 65535);
					cfg_vals[REG_THROTTLE] = $urandom_range(0, 511);
					cfg_vals[REG_WD_TICKS] = $urandom_range(1, 12);
					cfg_vals[REG_TH_TICKS] = $urandom_range(1, 8);
					cfg_vals[REG_AMBIENT] = {16'd0, r[15:0]};
					cfg_vals[REG_HEAT_GAIN] = pick_gain();
					cfg_vals[REG_INV_CAP] = pick_gain();
					cfg_vals[REG_LOSS_GAIN] = pick_gain();
				end
			endcase
			for (int i = 0; i < 8; i++) apb_write(reg_idx_t'(i), cfg_vals[i]);

			// idling mode of this phase
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
				default: begin send_idle_pct = 7; recv_stall_pct = 7; end
			endcase
			if (p == HOLD_PHASE) begin
				send_idle_pct = 0;
				hold_req = 1'b1;
			end

			// mostly a command followed by a run of ticks, some noise words
			wd_hint = (cfg_vals[REG_WD_TICKS] > 12) ? 12 : cfg_vals[REG_WD_TICKS];
			start = items_queued;
			while (items_queued - start < PHASE_WORDS) begin
				if ($urandom_range(0, 9) == 0) begin
					r = $urandom;
					push_cmd(r[20], r[9:0], r[19:10]);
				end else begin
					push_cmd(OP_STICK, pick_stick(), pick_stick());
					burst = $urandom_range(0, 2 * wd_hint + 2);
					repeat (burst) push_cmd(OP_TICK, pick_stick(), pick_stick());
				end
			end
		end

		// drain, then let any stray word show up
		while (results_seen != items_queued) @(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bridge_exp_q.size() != 0)
			report_mismatch("results never delivered", 0, bridge_exp_q.size());
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hdl/ddwt_pkg.sv
hdl/ddwt_regs.sv
hdl/ddwt_seq.sv
hdl/ddwt_dp.sv
hdl/differential_drive_watchdog_thermal.sv
test/tb_top.sv
